### rtl/core/cgi_pkg.sv
package cgi_pkg;

   localparam int POINTS_DEF = 64;

   localparam int FREQ_W    = 32;
   localparam int GAIN_W    = 8;
   localparam int ENTRY_W   = FREQ_W + GAIN_W;
   localparam int IDX_W     = 6;
   localparam int OUT_GAIN_W = 6;
   localparam int STATUS_W  = 2;

   // Divider sizing: |2*df*dg + span| < 2^42, divisor 2*span < 2^33,
   // and the quotient magnitude stays below 2^9.
   localparam int MAG_W  = 42;
   localparam int DIV_W  = 33;
   localparam int QUOT_W = 9;

   localparam int CSR_IDX_W = 1;
   localparam int CSR_W     = 32;

   localparam logic [CSR_IDX_W-1:0] CSR_FREQ_LOW  = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FREQ_HIGH = 1'd1;

   localparam logic OP_LOAD   = 1'b0;
   localparam logic OP_LOOKUP = 1'b1;

   localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_RANGE = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_NOSEG = 2'd2;
   localparam logic [STATUS_W-1:0] STAT_BIG   = 2'd3;

   localparam int GAIN_MAX = 63;

   typedef struct packed {
      logic              opcode;
      logic [IDX_W-1:0]  point_index;
      logic [FREQ_W-1:0] point_freq;
      logic [GAIN_W-1:0] point_gain;
      logic [FREQ_W-1:0] query_freq;
   } req_type;

   typedef struct packed {
      logic [OUT_GAIN_W-1:0] gain_out;
      logic [STATUS_W-1:0]   status;
      logic [IDX_W-1:0]      segment_index;
   } rsp_type;

   typedef struct packed {
      logic              done;
      logic [QUOT_W-1:0] quot;
      logic              rem_nz;
   } div_result_type;

endpackage

### rtl/core/cgi_ram.sv
module cgi_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/core/cgi_div.sv
module cgi_div (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [cgi_pkg::MAG_W-1:0]      mag,
   input  logic [cgi_pkg::DIV_W-1:0]      divisor,
   output cgi_pkg::div_result_type        result
);

   import cgi_pkg::*;

   localparam int STEP_W = $clog2(QUOT_W + 1);

   logic [MAG_W-1:0]  rem_ff, rem_in;
   logic [MAG_W-1:0]  dsh_ff, dsh_in;
   logic [QUOT_W-1:0] quot_ff, quot_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;

   // Restoring division, one quotient bit per cycle, most significant first.
   always_comb begin
      rem_in  = rem_ff;
      dsh_in  = dsh_ff;
      quot_in = quot_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = mag;
         dsh_in  = {{(MAG_W - DIV_W - QUOT_W + 1){1'b0}}, divisor, {(QUOT_W - 1){1'b0}}};
         quot_in = '0;
         step_in = STEP_W'(QUOT_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (rem_ff >= dsh_ff) begin
            rem_in  = rem_ff - dsh_ff;
            quot_in = {quot_ff[QUOT_W-2:0], 1'b1};
         end else begin
            quot_in = {quot_ff[QUOT_W-2:0], 1'b0};
         end
         dsh_in  = dsh_ff >> 1;
         step_in = step_ff - 1'b1;
         if (step_ff == STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      dsh_ff  <= dsh_in;
      quot_ff <= quot_in;
      step_ff <= step_in;
   end

   assign result = {done_ff, quot_ff, (rem_ff != '0)};

endmodule

### rtl/core/calibration_gain_interpolator_core.sv
// Channel   Direction  Ports                         Moves
// request   in         req_valid, req_stall, req_data  one load or one lookup
// response  out        rsp_valid, rsp_stall, rsp_data  one result per request
// csr       in         csr_write, csr_index, csr_wdata frequency limits
//
// A load, and a lookup rejected by the limits, go straight to the finish state.
// A lookup that scans the table reads one table entry per cycle through the
// single RAM read port, then the serial divider works out the quotient. One
// item is worked on at a time.
// Reset is synchronous and clears control state and the limits; the table RAM
// is not cleared. A stalled result waits in the output register while the next
// request is taken; the block stalls requests only while an item is at work.
module calibration_gain_interpolator_core #(
   parameter int POINTS = cgi_pkg::POINTS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  cgi_pkg::req_type              req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output cgi_pkg::rsp_type              rsp_data,
   input  logic                          csr_write,
   input  logic [cgi_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [cgi_pkg::CSR_W-1:0]     csr_wdata
);

   import cgi_pkg::*;

   localparam int AW = $clog2(POINTS);
   localparam logic [AW-1:0] LAST_ADDR = AW'(POINTS - 1);

   typedef enum logic [7:0] {
      S_IDLE   = 8'b0000_0001,
      S_SCAN   = 8'b0000_0010,
      S_DRAIN  = 8'b0000_0100,
      S_MULT   = 8'b0000_1000,
      S_PREP   = 8'b0001_0000,
      S_DIV    = 8'b0010_0000,
      S_FIX    = 8'b0100_0000,
      S_FINISH = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;

   logic [FREQ_W-1:0] low_ff, low_in;
   logic [FREQ_W-1:0] high_ff, high_in;
   logic [FREQ_W-1:0] q_ff, q_in;
   logic [AW-1:0]     cnt_ff, cnt_in;
   logic              dvld_ff, dvld_in;
   logic [AW-1:0]     didx_ff, didx_in;
   logic [FREQ_W-1:0] prev_f_ff, prev_f_in;
   logic [GAIN_W-1:0] prev_g_ff, prev_g_in;
   logic              found_ff, found_in;
   logic [AW-1:0]     seg_ff, seg_in;
   logic [FREQ_W-1:0] f0_ff, f0_in;
   logic [FREQ_W-1:0] f1_ff, f1_in;
   logic [GAIN_W-1:0] g0_ff, g0_in;
   logic [GAIN_W-1:0] g1_ff, g1_in;
   logic [FREQ_W+GAIN_W-1:0] p_ff, p_in;
   logic [FREQ_W-1:0] span_ff, span_in;
   logic              negdg_ff, negdg_in;
   logic              negq_ff, negq_in;
   rsp_type           res_ff, res_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_data_ff, rsp_data_in;

   logic               ram_we;
   logic [AW-1:0]      ram_waddr;
   logic [ENTRY_W-1:0] ram_rdata;
   logic               ram_re;
   logic [FREQ_W-1:0]  cur_f;
   logic [GAIN_W-1:0]  cur_g;

   logic                 div_start;
   logic [MAG_W-1:0]     div_mag;
   div_result_type       div_res;

   logic [FREQ_W-1:0]    df;
   logic [GAIN_W:0]      dg;
   logic [GAIN_W-1:0]    abs_dg;
   logic [FREQ_W+GAIN_W:0] twop;
   logic signed [QUOT_W+1:0] delta;
   logic signed [QUOT_W+1:0] gsum;

   logic accept;

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != S_IDLE);

   assign ram_we    = accept && (req_data.opcode == OP_LOAD) &&
                      (32'(req_data.point_index) < POINTS);
   assign ram_waddr = AW'(req_data.point_index);
   assign ram_re    = (state_ff == S_SCAN);
   assign cur_f     = ram_rdata[ENTRY_W-1:GAIN_W];
   assign cur_g     = ram_rdata[GAIN_W-1:0];

   cgi_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (POINTS)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data ({req_data.point_freq, req_data.point_gain}),
      .rd_en   (ram_re),
      .rd_addr (cnt_ff),
      .rd_data (ram_rdata)
   );

   // Magnitude of 2*df*dg + span; a falling slope gives a negative numerator
   // once 2*df*|dg| exceeds the span.
   assign twop = {p_ff, 1'b0};
   always_comb begin
      div_mag = '0;
      negq_in = negq_ff;
      if (state_ff == S_PREP) begin
         if (!negdg_ff) begin
            div_mag = MAG_W'(twop) + MAG_W'(span_ff);
            negq_in = 1'b0;
         end else if (twop >= (FREQ_W+GAIN_W+1)'(span_ff)) begin
            div_mag = MAG_W'(twop - (FREQ_W+GAIN_W+1)'(span_ff));
            negq_in = 1'b1;
         end else begin
            div_mag = MAG_W'((FREQ_W+GAIN_W+1)'(span_ff) - twop);
            negq_in = 1'b0;
         end
      end
   end

   assign div_start = (state_ff == S_PREP);

   cgi_div u_div (
      .clock   (clock),
      .reset   (reset),
      .start   (div_start),
      .mag     (div_mag),
      .divisor ({span_ff, 1'b0}),
      .result  (div_res)
   );

   assign df     = q_ff - f0_ff;
   assign dg     = {1'b0, g1_ff} - {1'b0, g0_ff};
   assign abs_dg = dg[GAIN_W] ? GAIN_W'(-dg) : dg[GAIN_W-1:0];

   // Floor of a negative quotient rounds away from zero when bits remain.
   always_comb begin
      if (negq_ff) begin
         delta = -($signed({2'b00, div_res.quot}) +
                   $signed({{(QUOT_W+1){1'b0}}, div_res.rem_nz}));
      end else begin
         delta = $signed({2'b00, div_res.quot});
      end
      gsum = $signed({{(QUOT_W+2-GAIN_W){1'b0}}, g0_ff}) + delta;
   end

   always_comb begin
      low_in  = low_ff;
      high_in = high_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_FREQ_LOW:  low_in  = csr_wdata;
            CSR_FREQ_HIGH: high_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      state_in  = state_ff;
      q_in      = q_ff;
      cnt_in    = cnt_ff;
      dvld_in   = (state_ff == S_SCAN);
      didx_in   = cnt_ff;
      prev_f_in = prev_f_ff;
      prev_g_in = prev_g_ff;
      found_in  = found_ff;
      seg_in    = seg_ff;
      f0_in     = f0_ff;
      f1_in     = f1_ff;
      g0_in     = g0_ff;
      g1_in     = g1_ff;
      p_in      = p_ff;
      span_in   = span_ff;
      negdg_in  = negdg_ff;
      res_in    = res_ff;

      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;

      // Pair each arriving entry with the one before it; a later match wins.
      if (dvld_ff) begin
         prev_f_in = cur_f;
         prev_g_in = cur_g;
         if ((didx_ff != '0) && (q_ff >= prev_f_ff) && (q_ff < cur_f)) begin
            found_in = 1'b1;
            seg_in   = didx_ff - 1'b1;
            f0_in    = prev_f_ff;
            g0_in    = prev_g_ff;
            f1_in    = cur_f;
            g1_in    = cur_g;
         end
      end

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               res_in = '0;
               unique case (req_data.opcode)
                  OP_LOAD: begin
                     state_in = S_FINISH;
                  end
                  OP_LOOKUP: begin
                     q_in = req_data.query_freq;
                     if ((req_data.query_freq < low_ff) ||
                         (req_data.query_freq > high_ff)) begin
                        res_in.status = STAT_RANGE;
                        state_in      = S_FINISH;
                     end else begin
                        cnt_in   = '0;
                        found_in = 1'b0;
                        state_in = S_SCAN;
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_SCAN: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == LAST_ADDR) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            state_in = S_MULT;
         end
         S_MULT: begin
            if (!found_ff) begin
               res_in.status = STAT_NOSEG;
               state_in      = S_FINISH;
            end else begin
               p_in     = df * abs_dg;
               span_in  = f1_ff - f0_ff;
               negdg_in = dg[GAIN_W];
               state_in = S_PREP;
            end
         end
         S_PREP: begin
            state_in = S_DIV;
         end
         S_DIV: begin
            if (div_res.done) begin
               state_in = S_FIX;
            end
         end
         S_FIX: begin
            res_in.segment_index = IDX_W'(seg_ff);
            if ((gsum > $signed((QUOT_W+2)'(GAIN_MAX))) || (gsum < 0)) begin
               res_in.status = STAT_BIG;
            end else begin
               res_in.status   = STAT_OK;
               res_in.gain_out = OUT_GAIN_W'(gsum);
            end
            state_in = S_FINISH;
         end
         S_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         low_ff       <= '0;
         high_ff      <= '1;
         dvld_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         found_ff     <= 1'b0;
      end else begin
         state_ff     <= state_in;
         low_ff       <= low_in;
         high_ff      <= high_in;
         dvld_ff      <= dvld_in;
         rsp_valid_ff <= rsp_valid_in;
         found_ff     <= found_in;
      end
   end

   always_ff @(posedge clock) begin
      q_ff        <= q_in;
      cnt_ff      <= cnt_in;
      didx_ff     <= didx_in;
      prev_f_ff   <= prev_f_in;
      prev_g_ff   <= prev_g_in;
      seg_ff      <= seg_in;
      f0_ff       <= f0_in;
      f1_ff       <= f1_in;
      g0_ff       <= g0_in;
      g1_ff       <= g1_in;
      p_ff        <= p_in;
      span_ff     <= span_in;
      negdg_ff    <= negdg_in;
      negq_ff     <= negq_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
